FILE: sv/tbwt_pkg.sv
package tbwt_pkg;

	localparam int VTX_W   = 12;
	localparam int DEPTH   = 4096;
	localparam int CNT_W   = 13;
	localparam int BONE_W  = 8;
	localparam int WGT_W   = 16;
	localparam int SUM_W   = 18;
	localparam int ENTRY_W = 4 * BONE_W + 4 * WGT_W;

	localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;
	localparam logic [WGT_W-1:0] SHARE_FULL  = 16'hFFFF;

	localparam logic [1:0] ST_STORED  = 2'd0;
	localparam logic [1:0] ST_SKIPPED = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;
	localparam logic [1:0] ST_READ    = 2'd3;

	typedef struct packed {
		logic clear;
		logic capture;
		logic add_commit;
		logic read_init;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic op_read;
		logic sum_zero;
		logic div_last;
	} sts_t;

endpackage

FILE: sv/tbwt_in_if.sv
interface tbwt_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic [11:0]        vertex_id;
	logic signed [8:0]  bone_index;
	logic [15:0]        weight;

	modport source (output valid, op, vertex_id, bone_index, weight, input ready);
	modport sink (input valid, op, vertex_id, bone_index, weight, output ready);
endinterface

FILE: sv/tbwt_out_if.sv
interface tbwt_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  bone_a;
	logic [7:0]  bone_b;
	logic [7:0]  bone_c;
	logic [7:0]  bone_d;
	logic [15:0] share_a;
	logic [15:0] share_b;
	logic [15:0] share_c;
	logic [15:0] share_d;

	modport source (output valid, status, bone_a, bone_b, bone_c, bone_d,
		share_a, share_b, share_c, share_d, input ready);
	modport sink (input valid, status, bone_a, bone_b, bone_c, bone_d,
		share_a, share_b, share_c, share_d, output ready);
endinterface

FILE: sv/top4_bone_weight_table.sv
// Keeps the four strongest (bone, weight) influences for each of 4096 vertices and answers
// reads with the weights normalized to their sum. After reset the table is swept clear, one
// entry a cycle, during which no word is accepted. An add reads the table entry, updates it and
// loads the result. A read runs one shared restoring divider that produces one quotient bit per
// cycle, sixteen bits for each of the four shares. A read of an unweighted or out-of-range
// vertex skips the divider.
module top4_bone_weight_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       write_enable,
	input  logic [tbwt_pkg::CNT_W-1:0] write_data,
	tbwt_in_if.sink                    in_ch,
	tbwt_out_if.source                 out_ch
);

	tbwt_pkg::cmd_t              cmd;
	tbwt_pkg::sts_t              sts;
	logic [tbwt_pkg::BONE_W-1:0] bone [4];
	logic [tbwt_pkg::WGT_W-1:0]  share [4];

	tbwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tbwt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (write_enable),
		.cfg_data   (write_data),
		.in_op      (in_ch.op),
		.in_vertex  (in_ch.vertex_id),
		.in_bone    (in_ch.bone_index),
		.in_weight  (in_ch.weight),
		.cmd        (cmd),
		.sts        (sts),
		.out_status (out_ch.status),
		.out_bone   (bone),
		.out_share  (share)
	);

	assign out_ch.bone_a  = bone[0];
	assign out_ch.bone_b  = bone[1];
	assign out_ch.bone_c  = bone[2];
	assign out_ch.bone_d  = bone[3];
	assign out_ch.share_a = share[0];
	assign out_ch.share_b = share[1];
	assign out_ch.share_c = share[2];
	assign out_ch.share_d = share[3];

endmodule

FILE: sv/tbwt_ctrl.sv
module tbwt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  tbwt_pkg::sts_t sts,
	output tbwt_pkg::cmd_t cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LOOK  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_LOOK;
				end
			end
			S_LOOK: begin
				if (sts.op_read) begin
					cmd.read_init = 1'b1;
					state_d       = sts.sum_zero ? S_DONE : S_DIV;
				end else begin
					cmd.add_commit = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/tbwt_dp.sv
module tbwt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tbwt_pkg::CNT_W-1:0]    cfg_data,
	input  logic                          in_op,
	input  logic [tbwt_pkg::VTX_W-1:0]    in_vertex,
	input  logic signed [8:0]             in_bone,
	input  logic [tbwt_pkg::WGT_W-1:0]    in_weight,
	input  tbwt_pkg::cmd_t                cmd,
	output tbwt_pkg::sts_t                sts,
	output logic [1:0]                    out_status,
	output logic [tbwt_pkg::BONE_W-1:0]   out_bone [4],
	output logic [tbwt_pkg::WGT_W-1:0]    out_share [4]
);

	logic [tbwt_pkg::ENTRY_W-1:0] mem_q [tbwt_pkg::DEPTH];
	logic [tbwt_pkg::ENTRY_W-1:0] rd_q;
	logic [tbwt_pkg::VTX_W-1:0]   clr_q;
	logic [tbwt_pkg::CNT_W-1:0]   count_q;

	logic                         op_q;
	logic [tbwt_pkg::VTX_W-1:0]   vtx_q;
	logic signed [8:0]            bone_q;
	logic [tbwt_pkg::WGT_W-1:0]   w_q;

	logic [tbwt_pkg::WGT_W-1:0]   wt [4];
	logic [tbwt_pkg::BONE_W-1:0]  bt [4];
	logic                         in_range;
	logic                         valid_add;
	logic                         store;
	logic [2:0]                   slot;
	logic [tbwt_pkg::WGT_W-1:0]   smallest;
	logic                         found;
	logic [tbwt_pkg::ENTRY_W-1:0] new_entry;
	logic [tbwt_pkg::SUM_W-1:0]   sum_eff;

	logic                         we;
	logic [tbwt_pkg::VTX_W-1:0]   wa;
	logic [tbwt_pkg::ENTRY_W-1:0] wd;

	logic [1:0]                   res_status_q;
	logic [tbwt_pkg::BONE_W-1:0]  res_bone_q [4];
	logic [tbwt_pkg::WGT_W-1:0]   res_share_q [4];
	logic [tbwt_pkg::WGT_W-1:0]   wsave_q [4];
	logic [tbwt_pkg::SUM_W-1:0]   sum_q;
	logic [tbwt_pkg::SUM_W-1:0]   rem_q;
	logic [tbwt_pkg::WGT_W-1:0]   low_q;
	logic [tbwt_pkg::WGT_W-1:0]   quo_q;
	logic [3:0]                   bit_q;
	logic [1:0]                   k_q;
	logic [1:0]                   k_next;

	logic [tbwt_pkg::SUM_W:0]     trial;
	logic [tbwt_pkg::SUM_W:0]     diff;
	logic                         ge;
	logic [tbwt_pkg::WGT_W-1:0]   quo_next;
	logic [31:0]                  num_first;
	logic [31:0]                  num_next;
	logic [tbwt_pkg::WGT_W-1:0]   w_first;

	always_comb begin
		for (int s = 0; s < 4; s++) begin
			wt[s] = rd_q[s*tbwt_pkg::WGT_W +: tbwt_pkg::WGT_W];
			bt[s] = rd_q[4*tbwt_pkg::WGT_W + s*tbwt_pkg::BONE_W +: tbwt_pkg::BONE_W];
		end
	end

	assign in_range  = ({1'b0, vtx_q} < count_q);
	assign valid_add = (w_q != '0) && !bone_q[8] && in_range;

	always_comb begin
		slot     = 3'd4;
		smallest = w_q;
		found    = 1'b0;
		for (int s = 0; s < 4; s++) begin
			if (!found) begin
				if (wt[s] == '0) begin
					slot  = 3'(s);
					found = 1'b1;
				end else if (wt[s] < smallest) begin
					smallest = wt[s];
					slot     = 3'(s);
				end
			end
		end
	end

	assign store = valid_add && (slot != 3'd4);

	always_comb begin
		new_entry = rd_q;
		for (int s = 0; s < 4; s++) begin
			if (slot == 3'(s)) begin
				new_entry[s*tbwt_pkg::WGT_W +: tbwt_pkg::WGT_W] = w_q;
				new_entry[4*tbwt_pkg::WGT_W + s*tbwt_pkg::BONE_W +: tbwt_pkg::BONE_W] =
					bone_q[7:0];
			end
		end
	end

	assign sum_eff = in_range ? (18'(wt[0]) + 18'(wt[1]) + 18'(wt[2]) + 18'(wt[3])) : '0;

	assign we = cmd.clear | (cmd.add_commit & store);
	assign wa = cmd.clear ? clr_q : vtx_q;
	assign wd = cmd.clear ? '0 : new_entry;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (cmd.capture) begin
			rd_q <= mem_q[in_vertex];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			count_q <= tbwt_pkg::COUNT_RESET;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				count_q <= cfg_data;
			end
		end
	end

	assign sts.clear_last = &clr_q;
	assign sts.op_read    = op_q;
	assign sts.sum_zero   = (sum_eff == '0);
	assign sts.div_last   = (k_q == 2'd3) && (bit_q == 4'd15);

	assign trial    = {rem_q, low_q[tbwt_pkg::WGT_W-1]};
	assign diff     = trial - {1'b0, sum_q};
	assign ge       = (trial >= {1'b0, sum_q});
	assign quo_next = {quo_q[tbwt_pkg::WGT_W-2:0], ge};
	assign k_next   = k_q + 2'd1;
	assign w_first  = in_range ? wt[0] : '0;
	assign num_first = {w_first, 16'h0000} - {16'h0000, w_first};
	assign num_next  = {wsave_q[k_next], 16'h0000} - {16'h0000, wsave_q[k_next]};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_op;
			vtx_q  <= in_vertex;
			bone_q <= in_bone;
			w_q    <= in_weight;
		end
		if (cmd.add_commit) begin
			res_status_q <= store ? tbwt_pkg::ST_STORED :
				(valid_add ? tbwt_pkg::ST_DROPPED : tbwt_pkg::ST_SKIPPED);
			for (int s = 0; s < 4; s++) begin
				res_bone_q[s]  <= '0;
				res_share_q[s] <= '0;
			end
		end
		if (cmd.read_init) begin
			res_status_q <= tbwt_pkg::ST_READ;
			for (int s = 0; s < 4; s++) begin
				res_bone_q[s]  <= in_range ? bt[s] : '0;
				wsave_q[s]     <= in_range ? wt[s] : '0;
				res_share_q[s] <= (s == 0 && sum_eff == '0) ? tbwt_pkg::SHARE_FULL : '0;
			end
			sum_q <= sum_eff;
			rem_q <= {2'b00, num_first[31:16]};
			low_q <= num_first[15:0];
			quo_q <= '0;
			bit_q <= '0;
			k_q   <= '0;
		end
		if (cmd.div_step) begin
			if (bit_q == 4'd15) begin
				res_share_q[k_q] <= quo_next;
				k_q   <= k_next;
				bit_q <= '0;
				quo_q <= '0;
				rem_q <= {2'b00, num_next[31:16]};
				low_q <= num_next[15:0];
			end else begin
				rem_q <= ge ? diff[tbwt_pkg::SUM_W-1:0] : trial[tbwt_pkg::SUM_W-1:0];
				low_q <= {low_q[tbwt_pkg::WGT_W-2:0], 1'b0};
				quo_q <= quo_next;
				bit_q <= bit_q + 4'd1;
			end
		end
		if (cmd.load_out) begin
			out_status <= res_status_q;
			out_bone   <= res_bone_q;
			out_share  <= res_share_q;
		end
	end

endmodule

FILE: sv/tbwt_checker.sv
module tbwt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [7:0]  bone_a,
	input logic [7:0]  bone_b,
	input logic [7:0]  bone_c,
	input logic [7:0]  bone_d,
	input logic [15:0] share_a,
	input logic [15:0] share_b,
	input logic [15:0] share_c,
	input logic [15:0] share_d
);

	// A stalled result word holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(share_a))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != tbwt_pkg::ST_READ |->
		bone_a == 8'd0 && bone_b == 8'd0 && bone_c == 8'd0 && bone_d == 8'd0 &&
		share_a == 16'd0 && share_b == 16'd0 && share_c == 16'd0 && share_d == 16'd0)
		else $error("add result carries data");

	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == tbwt_pkg::ST_READ |->
		(18'(share_a) + 18'(share_b) + 18'(share_c) + 18'(share_d)) <= 18'd65535)
		else $error("shares exceed one");

endmodule

bind top4_bone_weight_table tbwt_checker u_tbwt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.status    (out_ch.status),
	.bone_a    (out_ch.bone_a),
	.bone_b    (out_ch.bone_b),
	.bone_c    (out_ch.bone_c),
	.bone_d    (out_ch.bone_d),
	.share_a   (out_ch.share_a),
	.share_b   (out_ch.share_b),
	.share_c   (out_ch.share_c),
	.share_d   (out_ch.share_d)
);
